### hdl/id3ff_pkg.sv
// -----------------------------------------------------------------------------
// id3ff_pkg
// Types and constants shared by the ID3v2 frame finder.
// -----------------------------------------------------------------------------
package id3ff_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_ID  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALL_FRAMES = 1'd1;
	localparam int unsigned CFG_DATA_W = 32;

	// header lengths and synchsafe layout
	localparam logic [3:0] HDR_LEN        = 4'd10;
	localparam logic [3:0] HDR_SIZE_START = 4'd6;  // tag header: size bytes 6..9
	localparam logic [3:0] FRM_ID_END     = 4'd4;  // frame header: id bytes 0..3
	localparam logic [3:0] FRM_SIZE_END   = 4'd8;  // frame header: size bytes 4..7

	typedef enum logic [1:0] {
		KIND_HEADER    = 2'd0,
		KIND_PAYLOAD   = 2'd1,
		KIND_NOT_FOUND = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       first;
	} id3ff_in_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] frame_id;
		logic [27:0] frame_size;
		logic [7:0]  out_byte;
		logic        last;
		logic        tag_done;
	} id3ff_out_t;

endpackage

### hdl/id3v2_frame_finder_top.sv
// -----------------------------------------------------------------------------
// id3v2_frame_finder_top
// Byte-serial ID3v2 tag parser: finds one frame by id, or passes every frame.
// -----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in      | into      | in_valid / in_stall   | in_data  (id3ff_in_t)
//  out     | out of    | out_valid / out_stall | out_data (id3ff_out_t)
//  cfg     | into      | cfg_wr_en             | cfg_index, cfg_wdata
//
// One byte per clock sustained while the output does not stall. A request
// lands in the input register, the parser step runs between that register
// and the result register, so each result leaves from the result register.
// Bytes that give no result pass the input register regardless of
// the output side. A pending result blocks only while the result register
// is full and stalled. Reset clears the parser to wait for a tag header;
// control and parser registers reset to zero, payload registers do not.
module id3v2_frame_finder_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  id3ff_pkg::id3ff_in_t                 in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output id3ff_pkg::id3ff_out_t                out_data,
	input  logic                                 cfg_wr_en,
	input  logic [id3ff_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [id3ff_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import id3ff_pkg::*;

	typedef enum logic [2:0] {
		PH_TAG,    // reading the 10-byte tag header
		PH_FRAME,  // reading a 10-byte frame header
		PH_EMIT,   // passing payload bytes out
		PH_SKIP,   // dropping payload of an unwanted frame
		PH_DONE    // tag finished, wait for first
	} phase_t;

	// configuration
	logic [31:0] target_id_q;
	logic        all_frames_q;

	// parser state
	phase_t      phase_q;
	logic [3:0]  hdr_cnt_q;
	logic [27:0] tag_left_q;
	logic [31:0] cur_id_q;
	logic [27:0] cur_size_q;
	logic [27:0] payload_left_q;
	logic        final_q;
	logic        emit_all_q;

	// input register
	id3ff_in_t   in_s1;
	logic        vld_s1;

	// result register
	id3ff_out_t  out_q;
	logic        out_vld_q;

	// next-state values
	phase_t      nxt_phase;
	logic [3:0]  nxt_hdr_cnt;
	logic [27:0] nxt_tag_left;
	logic [31:0] nxt_cur_id;
	logic [27:0] nxt_cur_size;
	logic [27:0] nxt_payload_left;
	logic        nxt_final;
	logic        nxt_emit_all;
	logic        res_vld;
	id3ff_out_t  res;

	// step helpers
	phase_t      ph;
	logic [3:0]  hc;
	logic [3:0]  hc_inc;
	logic [7:0]  b;
	logic [27:0] size_shift;
	logic [28:0] size_plus;
	logic        fin;
	logic        match;
	logic        size_zero;
	logic        done;
	logic [27:0] pl_dec;
	logic        pl_zero;

	logic        advance;

	always_comb begin
		b          = in_s1.in_byte;
		ph         = in_s1.first ? PH_TAG : phase_q;
		hc         = in_s1.first ? 4'd0 : hdr_cnt_q;
		hc_inc     = hc + 4'd1;
		size_shift = {cur_size_q[20:0], b[6:0]};
		size_plus  = {1'b0, cur_size_q} + 29'd10;
		fin        = size_plus >= {1'b0, tag_left_q};
		match      = all_frames_q || (cur_id_q == target_id_q);
		size_zero  = (cur_size_q == 28'd0);
		pl_dec     = payload_left_q - 28'd1;
		pl_zero    = (pl_dec == 28'd0);
		done       = 1'b0;

		nxt_phase        = ph;
		nxt_hdr_cnt      = hc;
		nxt_tag_left     = tag_left_q;
		nxt_cur_id       = cur_id_q;
		nxt_cur_size     = cur_size_q;
		nxt_payload_left = payload_left_q;
		nxt_final        = final_q;
		nxt_emit_all     = emit_all_q;
		res_vld          = 1'b0;
		res              = '0;

		case (ph)
			PH_TAG: begin
				if (hc >= HDR_SIZE_START) begin
					nxt_cur_size = size_shift;
				end
				nxt_hdr_cnt = hc_inc;
				if (hc_inc == HDR_LEN) begin
					nxt_hdr_cnt  = 4'd0;
					nxt_tag_left = size_shift;
					if (size_shift == 28'd0) begin
						// empty tag
						nxt_phase = PH_DONE;
						if (!all_frames_q) begin
							res_vld      = 1'b1;
							res.kind     = KIND_NOT_FOUND;
							res.tag_done = 1'b1;
						end
					end else begin
						nxt_phase = PH_FRAME;
					end
				end
			end
			PH_FRAME: begin
				if (hc < FRM_ID_END) begin
					nxt_cur_id = {cur_id_q[23:0], b};
				end else if (hc < FRM_SIZE_END) begin
					nxt_cur_size = size_shift;
				end
				nxt_hdr_cnt = hc_inc;
				if (hc_inc == HDR_LEN) begin
					nxt_hdr_cnt      = 4'd0;
					nxt_final        = fin;
					// overrun clamps at zero
					nxt_tag_left     = fin ? 28'd0 : (tag_left_q - size_plus[27:0]);
					nxt_payload_left = cur_size_q;
					nxt_emit_all     = all_frames_q;
					if (match) begin
						done    = size_zero && (!all_frames_q || fin);
						res_vld = 1'b1;
						res.kind       = KIND_HEADER;
						res.frame_id   = cur_id_q;
						res.frame_size = cur_size_q;
						res.last       = size_zero;
						res.tag_done   = done;
						if (!size_zero) begin
							nxt_phase = PH_EMIT;
						end else begin
							nxt_phase = done ? PH_DONE : PH_FRAME;
						end
					end else if (!size_zero) begin
						nxt_phase = PH_SKIP;
					end else if (fin) begin
						nxt_phase    = PH_DONE;
						res_vld      = 1'b1;
						res.kind     = KIND_NOT_FOUND;
						res.tag_done = 1'b1;
					end
				end
			end
			PH_EMIT: begin
				nxt_payload_left = pl_dec;
				done = pl_zero && (!emit_all_q || final_q);
				if (pl_zero) begin
					nxt_phase = done ? PH_DONE : PH_FRAME;
				end
				res_vld        = 1'b1;
				res.kind       = KIND_PAYLOAD;
				res.frame_id   = cur_id_q;
				res.frame_size = cur_size_q;
				res.out_byte   = b;
				res.last       = pl_zero;
				res.tag_done   = done;
			end
			PH_SKIP: begin
				nxt_payload_left = pl_dec;
				if (pl_zero) begin
					if (final_q) begin
						nxt_phase    = PH_DONE;
						res_vld      = 1'b1;
						res.kind     = KIND_NOT_FOUND;
						res.tag_done = 1'b1;
					end else begin
						nxt_phase = PH_FRAME;
					end
				end
			end
			default: begin
				// PH_DONE: ignore bytes until first
			end
		endcase
	end

	// step fires when the request gives no result or has somewhere to put it
	assign advance   = vld_s1 && (!res_vld || !out_vld_q || !out_stall);
	assign in_stall  = vld_s1 && !advance;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_id_q    <= '0;
			all_frames_q   <= 1'b0;
			phase_q        <= PH_TAG;
			hdr_cnt_q      <= '0;
			tag_left_q     <= '0;
			cur_id_q       <= '0;
			cur_size_q     <= '0;
			payload_left_q <= '0;
			final_q        <= 1'b0;
			emit_all_q     <= 1'b0;
			vld_s1         <= 1'b0;
			out_vld_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_TARGET_ID:  target_id_q  <= cfg_wdata;
					REG_ALL_FRAMES: all_frames_q <= cfg_wdata[0];
					default: begin
					end
				endcase
			end

			if (advance) begin
				phase_q        <= nxt_phase;
				hdr_cnt_q      <= nxt_hdr_cnt;
				tag_left_q     <= nxt_tag_left;
				cur_id_q       <= nxt_cur_id;
				cur_size_q     <= nxt_cur_size;
				payload_left_q <= nxt_payload_left;
				final_q        <= nxt_final;
				emit_all_q     <= nxt_emit_all;
			end

			if (in_valid && !in_stall) begin
				vld_s1 <= 1'b1;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end

			if (advance && res_vld) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_s1 <= in_data;
		end
		if (advance && res_vld) begin
			out_q <= res;
		end
	end

endmodule
